>>> src/lbs_pkg.sv
package lbs_pkg;

  localparam int WEIGHTS = 4;
  localparam int WEIGHT_BITS = 16;
  localparam int CMDQ_DEPTH = 4;
  localparam int OUT_DEPTH = 16;
  localparam int NUM_CAM_REGS = 6;

  localparam logic [2:0] CMD_SKIN = 3'd4;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_SKIN = 1'b1
  } op_t;

  // one classified transaction between front and back
  typedef struct packed {
    op_t               op;
    logic [1:0]        col;
    logic [3:0][5:0]   bone;
    logic [3:0][16:0]  w;
    logic [2:0][31:0]  pos;
  } cmd_t;

  // result push from the back end
  typedef struct packed {
    logic             valid;
    logic [2:0][31:0] xyz;
  } res_t;

  function automatic logic [31:0] sat32(logic signed [65:0] v);
    logic signed [65:0] t;
    t = v;
    if (v > SAT_MAX) t = SAT_MAX;
    else if (v < SAT_MIN) t = SAT_MIN;
    return t[31:0];
  endfunction

endpackage

>>> src/lbs_ram.sv
module lbs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> src/lbs_fifo.sv
module lbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic do_push, do_pop;

  assign empty = (cnt_r == '0);
  assign full = (cnt_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> src/lbs_front.sv
module lbs_front #(
  parameter int MAX_BONES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  logic [2:0]        command,
  input  logic [3:0][5:0]   bone,
  input  logic [2:0][31:0]  coord,
  input  logic [3:0][16:0]  weight,
  output logic              full,
  input  logic              q_pop,
  output lbs_pkg::cmd_t     q_head,
  output logic              q_empty
);

  lbs_pkg::cmd_t cmd;
  logic keep;

  always_comb begin
    cmd.op = (command == lbs_pkg::CMD_SKIN) ? lbs_pkg::OP_SKIN : lbs_pkg::OP_LOAD;
    cmd.col = command[1:0];
    cmd.pos = coord;
    for (int k = 0; k < lbs_pkg::WEIGHTS; k++) begin
      // out of range bones drop out of the blend
      if ({3'b000, bone[k]} >= 9'(MAX_BONES)) begin
        cmd.bone[k] = '0;
        cmd.w[k] = '0;
      end else begin
        cmd.bone[k] = bone[k];
        cmd.w[k] = weight[k];
      end
    end
    if (command == lbs_pkg::CMD_SKIN) keep = 1'b1;
    else if (command < lbs_pkg::CMD_SKIN) keep = ({3'b000, bone[0]} < 9'(MAX_BONES));
    else keep = 1'b0;
  end

  lbs_fifo #(.WIDTH($bits(lbs_pkg::cmd_t)), .DEPTH(lbs_pkg::CMDQ_DEPTH)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc && keep),
    .din   (cmd),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty),
    .full  (full)
  );

endmodule

>>> src/lbs_back.sv
module lbs_back #(
  parameter int MAX_BONES = 64,
  parameter int FRAC_BITS = 16,
  localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1,
  localparam int RW = $clog2(lbs_pkg::OUT_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lbs_pkg::cmd_t         q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [2:0][3:0][31:0] cam,
  input  logic                  out_pop_acc,
  output lbs_pkg::res_t         res
);

  localparam logic signed [65:0] RND_F = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] RND_W = 66'sd1 <<< (lbs_pkg::WEIGHT_BITS - 1);

  logic [RW-1:0] reserved_r;
  logic is_skin, issue_skin;

  assign is_skin = (q_head.op == lbs_pkg::OP_SKIN);
  assign q_pop = !q_empty && (!is_skin || reserved_r < RW'(lbs_pkg::OUT_DEPTH));
  assign issue_skin = q_pop && is_skin;

  // output slots reserved from issue until the result is popped
  always_ff @(posedge clk) begin
    if (!rst_n) reserved_r <= '0;
    else if (issue_skin && !out_pop_acc) reserved_r <= reserved_r + 1'b1;
    else if (out_pop_acc && !issue_skin) reserved_r <= reserved_r - 1'b1;
  end

  // bone store: one copy per weight slot, one ram per column
  logic [95:0] rd [4][4];
  logic [AW-1:0] waddr;
  logic [3:0][AW-1:0] raddr;

  always_comb begin
    logic [8:0] b;
    b = {3'b000, q_head.bone[0]};
    waddr = b[AW-1:0];
    for (int k = 0; k < 4; k++) begin
      b = {3'b000, q_head.bone[k]};
      raddr[k] = b[AW-1:0];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_copy
    for (genvar c = 0; c < 4; c++) begin : g_col
      lbs_ram #(.WIDTH(96), .DEPTH(MAX_BONES)) u_ram (
        .clk   (clk),
        .we    (q_pop && !is_skin && q_head.col == 2'(c)),
        .waddr (waddr),
        .wdata (q_head.pos),
        .raddr (raddr[k]),
        .rdata (rd[k][c])
      );
    end
  end

  // stage 1: bone words come out of the rams
  logic v1_r;
  logic [3:0][16:0] w1_r;
  logic [2:0][31:0] pos1_r;
  // stage 2: weighted bone words
  logic v2_r;
  logic signed [49:0] p2_r [4][3][4];
  logic [19:0] ws2_r;
  logic [2:0][31:0] pos2_r;
  // stage 3: blended matrix
  logic v3_r;
  logic [31:0] bl3_r [3][4];
  logic [31:0] bl3_nxt [3][4];
  logic [31:0] wt3_r, wt3_nxt;
  logic [2:0][31:0] pos3_r;
  // stage 4: matrix times position
  logic v4_r;
  logic signed [63:0] q4_r [3][3];
  logic [31:0] t4_r [3];
  logic [31:0] wt4_r;
  // stage 5: skinned 4-vector
  logic v5_r;
  logic [31:0] sk5_r [4];
  logic [31:0] sk5_nxt [4];
  // stage 6: camera products
  logic v6_r;
  logic signed [63:0] cp6_r [3][4];

  always_comb begin
    logic signed [65:0] acc;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 66'(p2_r[0][r][c]) + 66'(p2_r[1][r][c]) + 66'(p2_r[2][r][c])
            + 66'(p2_r[3][r][c]);
        bl3_nxt[r][c] = lbs_pkg::sat32((acc + RND_W) >>> lbs_pkg::WEIGHT_BITS);
      end
    end
    acc = $signed({46'd0, ws2_r}) <<< FRAC_BITS;
    wt3_nxt = lbs_pkg::sat32((acc + RND_W) >>> lbs_pkg::WEIGHT_BITS);
  end

  always_comb begin
    logic signed [65:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = 66'($signed(t4_r[r]));
      for (int c = 0; c < 3; c++) acc = acc + ((66'(q4_r[r][c]) + RND_F) >>> FRAC_BITS);
      sk5_nxt[r] = lbs_pkg::sat32(acc);
    end
    sk5_nxt[3] = wt4_r;
  end

  always_comb begin
    logic signed [65:0] acc;
    res.valid = v6_r;
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) acc = acc + ((66'(cp6_r[r][c]) + RND_F) >>> FRAC_BITS);
      res.xyz[r] = lbs_pkg::sat32(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= issue_skin;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    w1_r <= q_head.w;
    pos1_r <= q_head.pos;
    for (int k = 0; k < 4; k++)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 4; c++)
          p2_r[k][r][c] <= $signed({1'b0, w1_r[k]}) * $signed(rd[k][c][32*r +: 32]);
    ws2_r <= 20'(w1_r[0]) + 20'(w1_r[1]) + 20'(w1_r[2]) + 20'(w1_r[3]);
    pos2_r <= pos1_r;
    bl3_r <= bl3_nxt;
    wt3_r <= wt3_nxt;
    pos3_r <= pos2_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) q4_r[r][c] <= $signed(bl3_r[r][c]) * $signed(pos3_r[c]);
      t4_r[r] <= bl3_r[r][3];
    end
    wt4_r <= wt3_r;
    sk5_r <= sk5_nxt;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) cp6_r[r][c] <= $signed(cam[r][c]) * $signed(sk5_r[c]);
  end

  a_reserved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    reserved_r <= RW'(lbs_pkg::OUT_DEPTH))
    else $error("reserved count above output depth");

  a_no_issue_when_booked: assert property (@(posedge clk) disable iff (!rst_n)
    !(issue_skin && reserved_r == RW'(lbs_pkg::OUT_DEPTH)))
    else $error("skin issued with no free output slot");

  a_pop_needs_reservation: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop_acc |-> reserved_r != '0)
    else $error("result popped without reservation");

endmodule

>>> src/linear_blend_skinning.sv
// channel   direction  handshake              payload
// in        input      push / full            command, bones a-d, coord xyz, weights a-d
// out       output     empty / pop            out_x, out_y, out_z
// cfg       input      cfg_we                 cfg_index, cfg_wdata (camera rows)
//
// one transaction per cycle in while full is low, one result per cycle out while empty is low
// from acceptance to the out ports a transaction passes the command queue, the back-end pipeline and the result queue
// the rate is set by the bone store: one ram per weight slot and column, one read each cycle
// reset is synchronous; bone store holds no reset and must be loaded before use
// a stalled output stalls the back end only once 16 results are booked in flight
module linear_blend_skinning #(
  parameter int MAX_BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_bone_a,
  input  logic [5:0]  in_bone_b,
  input  logic [5:0]  in_bone_c,
  input  logic [5:0]  in_bone_d,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [16:0] in_weight_a,
  input  logic [16:0] in_weight_b,
  input  logic [16:0] in_weight_c,
  input  logic [16:0] in_weight_d,
  // result transaction
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  // camera configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // camera registers, identity rows at reset
  logic [63:0] cam_r [lbs_pkg::NUM_CAM_REGS];
  logic [2:0][3:0][31:0] cam;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r[0] <= 64'h0000_0000_0001_0000;
      cam_r[1] <= 64'h0;
      cam_r[2] <= 64'h0001_0000_0000_0000;
      cam_r[3] <= 64'h0;
      cam_r[4] <= 64'h0;
      cam_r[5] <= 64'h0000_0000_0001_0000;
    end else if (cfg_we && cfg_index < 3'(lbs_pkg::NUM_CAM_REGS)) begin
      cam_r[cfg_index] <= cfg_wdata;
    end
  end

  // element (r, c) sits in register 2r + c/2, low half for even c
  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        cam[r][c] = (c % 2 == 1) ? cam_r[2*r + c/2][63:32] : cam_r[2*r + c/2][31:0];
  end

  logic in_acc;
  assign in_acc = push && !full;

  // front end: classify and queue
  lbs_pkg::cmd_t q_head;
  logic q_empty, q_pop;

  lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .command (in_command),
    .bone    ({in_bone_d, in_bone_c, in_bone_b, in_bone_a}),
    .coord   ({in_coord_z, in_coord_y, in_coord_x}),
    .weight  ({in_weight_d, in_weight_c, in_weight_b, in_weight_a}),
    .full    (full),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_empty (q_empty)
  );

  // back end: bone store, blend, skin, camera
  lbs_pkg::res_t res;
  logic out_pop_acc;
  logic out_full;
  logic [95:0] out_data;

  assign out_pop_acc = pop && !empty;

  lbs_back #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .cam         (cam),
    .out_pop_acc (out_pop_acc),
    .res         (res)
  );

  // result queue, slots booked by the back end before issue
  lbs_fifo #(.WIDTH(96), .DEPTH(lbs_pkg::OUT_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res.valid),
    .din   (res.xyz),
    .pop   (pop),
    .dout  (out_data),
    .empty (empty),
    .full  (out_full)
  );

  assign out_x = out_data[31:0];
  assign out_y = out_data[63:32];
  assign out_z = out_data[95:64];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !out_full)
    else $error("result pushed into full queue");

endmodule
